// File: design/dhot_pkg.sv
// Shared types and codes for the double hash open address table.
package dhot_pkg;
  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_LIVE = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;

  localparam logic [2:0] R_FOUND   = 3'd0;
  localparam logic [2:0] R_MISS    = 3'd1;
  localparam logic [2:0] R_NEW     = 3'd2;
  localparam logic [2:0] R_REPL    = 3'd3;
  localparam logic [2:0] R_REMOVED = 3'd4;
  localparam logic [2:0] R_FULL    = 3'd5;

  localparam logic CFG_TABLE_SIZE    = 1'b0;
  localparam logic CFG_PROBE_MODULUS = 1'b1;

  // Request from the sequencer to the shared modulo unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } dhot_mod_req_t;

  // Answer of the shared modulo unit.
  typedef struct packed {
    logic        done;
    logic [16:0] remainder;
  } dhot_mod_rsp_t;
endpackage

// File: design/dhot_ram.sv
// Generic single port RAM with registered read.
module dhot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One read per cycle, plus a write when we is set; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/dhot_mod.sv
// Shared restoring modulo unit, one quotient bit per cycle.
module dhot_mod (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dhot_pkg::dhot_mod_req_t req,
  output dhot_pkg::dhot_mod_rsp_t rsp
);
  import dhot_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  assign trial = {rem_r, quo_r[31]} - {1'b0, div_r};

  // While busy, shift one dividend bit into the remainder each cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[31]};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;
endmodule

// File: design/double_hash_open_address_table.sv
// Top level of the double hash open address table.
// Flow: 3 modulo passes, then read, wait and evaluate per probed slot, and a commit step for a new insert.
// One item at a time; the bit-serial modulo dominates.
// Reset: synchronous, active low. After reset a clearing pass marks every slot free,
// one slot per cycle, during which no item is accepted.
// Configuration writes are accepted at any time and are meant only while idle.
module double_hash_open_address_table #(
  parameter int SLOT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_hash_value,
  input  logic [31:0] in_key,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_data_out,
  output logic [7:0]  out_slot_index,
  output logic [8:0]  out_entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import dhot_pkg::*;

  localparam int AW = $clog2(SLOT_DEPTH);
  localparam int CW = $clog2(SLOT_DEPTH + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MODA  = 4'd2;
  localparam logic [3:0] S_MODB  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_MODC  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [8:0]    tsize_r, pmod_r;
  logic [1:0]    op_r;
  logic [31:0]   hash_r, key_r, din_r;
  logic [AW-1:0] start_r, addr_r, step_r, avail_r, addr_nxt;
  logic          have_r;
  logic [CW-1:0] live_r, live_nxt;
  logic [AW-1:0] clr_r;
  logic [2:0]    ost_r;
  logic [31:0]   odata_r;
  logic [7:0]    oslot_r;
  logic [AW:0]   sum;
  logic [16:0]   size_eff, mod_eff;

  dhot_mod_req_t mreq;
  dhot_mod_rsp_t mrsp;

  // Store ports.
  logic          st_we, kv_we, dt_we;
  logic [AW-1:0] ram_addr;
  logic [1:0]    st_wdata, st_rdata;
  logic [31:0]   h_rdata, k_rdata, d_rdata;

  dhot_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  dhot_ram #(.WIDTH(2), .DEPTH(SLOT_DEPTH)) u_status (
    .clk(clk), .we(st_we), .addr(ram_addr), .wdata(st_wdata), .rdata(st_rdata));
  dhot_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_hash (
    .clk(clk), .we(kv_we), .addr(ram_addr), .wdata(hash_r), .rdata(h_rdata));
  dhot_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_key (
    .clk(clk), .we(kv_we), .addr(ram_addr), .wdata(key_r), .rdata(k_rdata));
  dhot_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_data (
    .clk(clk), .we(dt_we), .addr(ram_addr), .wdata(din_r), .rdata(d_rdata));

  // Effective size saturated to 3..SLOT_DEPTH, modulus at least one.
  always_comb begin
    if (tsize_r < 9'd3) begin
      size_eff = 17'd3;
    end else if (32'(tsize_r) > SLOT_DEPTH) begin
      size_eff = 17'(SLOT_DEPTH);
    end else begin
      size_eff = 17'(tsize_r);
    end
    mod_eff = (pmod_r == 9'd0) ? 17'd1 : 17'(pmod_r);
  end

  // Next probe address, modulo size with one compare and subtract.
  assign sum = {1'b0, addr_r} + {1'b0, step_r};
  always_comb begin
    if (17'(sum) >= size_eff) begin
      addr_nxt = AW'(17'(sum) - size_eff);
    end else begin
      addr_nxt = sum[AW-1:0];
    end
  end

  logic is_match;
  assign is_match = (st_rdata == ST_LIVE) && (h_rdata == hash_r) && (k_rdata == key_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    live_nxt  = live_r;
    mreq.start    = 1'b0;
    mreq.dividend = hash_r;
    mreq.divisor  = size_eff;
    st_we = 1'b0;
    kv_we = 1'b0;
    dt_we = 1'b0;
    st_wdata = ST_LIVE;
    ram_addr = addr_r;
    case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_wdata = ST_FREE;
        ram_addr = clr_r;
        if (clr_r == AW'(SLOT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_SEARCH || in_opcode == OP_INSERT || in_opcode == OP_REMOVE) begin
            state_nxt = S_MODA;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MODA: begin
        if (mrsp.done) begin
          mreq.start   = 1'b1;
          mreq.divisor = mod_eff;
          state_nxt    = S_MODB;
        end
      end
      S_MODB: begin
        // Reduce the probe step modulo the size so one subtract wraps the address.
        if (mrsp.done) begin
          mreq.start    = 1'b1;
          mreq.dividend = 32'(mrsp.remainder) + 32'd1;
          mreq.divisor  = size_eff;
          state_nxt     = S_MODC;
        end
      end
      S_MODC: begin
        if (mrsp.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_RD;
        if (op_r == OP_INSERT) begin
          if (st_rdata == ST_FREE) begin
            state_nxt = S_COMMIT;
          end else if (is_match) begin
            dt_we     = 1'b1;
            state_nxt = S_OUT;
          end else if (addr_nxt == start_r) begin
            state_nxt = S_COMMIT;
          end
        end else begin
          if (st_rdata == ST_FREE) begin
            state_nxt = S_OUT;
          end else if (is_match) begin
            if (op_r == OP_REMOVE) begin
              st_we    = 1'b1;
              st_wdata = ST_DEAD;
              live_nxt = live_r - CW'(1);
            end
            state_nxt = S_OUT;
          end else if (addr_nxt == start_r) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_COMMIT: begin
        ram_addr  = avail_r;
        state_nxt = S_OUT;
        if (have_r) begin
          st_we    = 1'b1;
          kv_we    = 1'b1;
          dt_we    = 1'b1;
          live_nxt = live_r + CW'(1);
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_IDLE && in_valid) begin
      mreq.start    = 1'b1;
      mreq.dividend = in_hash_value;
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      live_r  <= '0;
      tsize_r <= 9'd151;
      pmod_r  <= 9'd149;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_TABLE_SIZE) begin
          tsize_r <= cfg_data;
        end else begin
          pmod_r <= cfg_data;
        end
      end
    end
    case (state_r)
      S_IDLE: begin
        op_r    <= in_opcode;
        hash_r  <= in_hash_value;
        key_r   <= in_key;
        din_r   <= in_data_in;
        have_r  <= 1'b0;
        avail_r <= '0;
        ost_r   <= R_MISS;
        odata_r <= '0;
        oslot_r <= '0;
      end
      S_MODA: begin
        start_r <= AW'(mrsp.remainder);
        addr_r  <= AW'(mrsp.remainder);
      end
      S_MODC: begin
        if (mrsp.done) begin
          step_r <= AW'(mrsp.remainder);
        end
      end
      S_EVAL: begin
        addr_r <= addr_nxt;
        if (op_r == OP_INSERT && st_rdata != ST_LIVE && !have_r) begin
          have_r  <= 1'b1;
          avail_r <= addr_r;
        end
        if (is_match) begin
          oslot_r <= 8'(addr_r);
          case (op_r)
            OP_SEARCH: begin
              ost_r   <= R_FOUND;
              odata_r <= d_rdata;
            end
            OP_REMOVE: ost_r <= R_REMOVED;
            default:   ost_r <= R_REPL;
          endcase
        end
      end
      S_COMMIT: begin
        if (have_r) begin
          ost_r   <= R_NEW;
          oslot_r <= 8'(avail_r);
        end else begin
          ost_r <= R_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = ost_r;
  assign out_data_out    = odata_r;
  assign out_slot_index  = oslot_r;
  assign out_entry_count = 9'(live_r);
endmodule
